[hdl/dfnp_pkg.sv]
// Shared types, constants and helper functions for the delimited field number parser.
// No dependencies; every other file in the block imports this package.
package dfnp_pkg;

	// Default build parameters.
	localparam int DEF_FIELDS_PER_LINE = 16;
	localparam int DEF_FRAC_DIGITS     = 4;

	// Field widths.
	localparam int IDX_W   = 5;
	localparam int INT_W   = 32;
	localparam int DEC_W   = 48;
	localparam int POW_W   = 20;
	localparam int SEEN_W  = 3;

	// Character codes.
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_DOT     = 8'd46;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;
	localparam logic [7:0] DELIM_RESET = 8'd124;

	// Scan phase codes for one field.
	localparam logic [1:0] PH_SKIP = 2'd0;
	localparam logic [1:0] PH_INT  = 2'd1;
	localparam logic [1:0] PH_FRAC = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// Saturation limits of the magnitudes.
	localparam logic [30:0] INT_MAX_MAG = '1;
	localparam logic [46:0] DEC_MAX_MAG = '1;

	// One result beat.
	typedef struct packed {
		logic [IDX_W-1:0]        field_index;
		logic signed [INT_W-1:0] int_value;
		logic signed [DEC_W-1:0] decimal_value;
		logic                    overflowed;
		logic                    field_kept;
		logic                    last_in_line;
	} res_t;

	// Powers of ten used for digit weights.
	function automatic logic [POW_W-1:0] pow10(input logic [SEEN_W-1:0] n);
		logic [POW_W-1:0] p;
		case (n)
			3'd0: p = 20'd1;
			3'd1: p = 20'd10;
			3'd2: p = 20'd100;
			3'd3: p = 20'd1000;
			3'd4: p = 20'd10000;
			3'd5: p = 20'd100000;
			3'd6: p = 20'd1000000;
			default: p = 20'd0;
		endcase
		return p;
	endfunction

endpackage

[hdl/dfnp_digit_acc.sv]
// Digit accumulation datapath: folds one decimal digit into the integer and
// fixed-point magnitudes with saturation. Depends on dfnp_pkg.
module dfnp_digit_acc #(
	parameter int FRAC_DIGITS = dfnp_pkg::DEF_FRAC_DIGITS
) (
	input  logic [30:0] int_acc,
	input  logic [46:0] dec_acc,
	input  logic [3:0]  digit,
	input  logic        frac_mode,
	input  logic [dfnp_pkg::SEEN_W-1:0] frac_pos,
	output logic [30:0] int_next,
	output logic [46:0] dec_next,
	output logic        ovf
);
	import dfnp_pkg::*;

	localparam logic [POW_W-1:0] INT_SCALE = pow10(SEEN_W'(FRAC_DIGITS));

	logic [34:0]       int_sum;
	logic [23:0]       int_weight;
	logic [23:0]       frac_weight;
	logic [SEEN_W-1:0] frac_exp;
	logic [51:0]       dec_sum;
	logic              int_ovf;
	logic              dec_ovf;

	// Integer magnitude times ten plus digit, built from shifts.
	always_comb begin
		int_sum = {1'b0, int_acc, 3'b000} + {3'b000, int_acc, 1'b0} + 35'(digit);
		int_ovf = int_sum > 35'(INT_MAX_MAG);
	end

	// Decimal magnitude: scale and add in integer mode, add weighted digit in fraction mode.
	always_comb begin
		int_weight  = 24'(digit) * 24'(INT_SCALE);
		frac_exp    = SEEN_W'(FRAC_DIGITS - 1) - frac_pos;
		frac_weight = 24'(digit) * 24'(pow10(frac_exp));
		if (frac_mode) begin
			dec_sum = 52'(dec_acc) + 52'(frac_weight);
		end else begin
			dec_sum = {2'b00, dec_acc, 3'b000} + {4'b0000, dec_acc, 1'b0} + 52'(int_weight);
		end
		dec_ovf = dec_sum > 52'(DEC_MAX_MAG);
	end

	// Saturate and report.
	always_comb begin
		if (frac_mode) begin
			int_next = int_acc;
		end else begin
			int_next = int_ovf ? INT_MAX_MAG : int_sum[30:0];
		end
		dec_next = dec_ovf ? DEC_MAX_MAG : dec_sum[46:0];
		ovf      = dec_ovf | (int_ovf & ~frac_mode);
	end

endmodule

[hdl/dfnp_parser.sv]
// Byte stage and per-field scan state: registers the incoming byte, advances the
// field scan and forms the result for a closed field. Depends on dfnp_pkg, dfnp_digit_acc.
module dfnp_parser #(
	parameter int MAX_FIELDS_PER_LINE = dfnp_pkg::DEF_FIELDS_PER_LINE,
	parameter int FRAC_DIGITS         = dfnp_pkg::DEF_FRAC_DIGITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     text_byte,
	input  logic [7:0]     delim,
	input  logic           out_free,
	output logic           res_load,
	output dfnp_pkg::res_t res
);
	import dfnp_pkg::*;

	localparam int FC_W = $clog2(MAX_FIELDS_PER_LINE + 1);

	logic [7:0]        byte_s1;
	logic              valid_s1;
	logic [FC_W-1:0]   fields_q;
	logic [1:0]        phase_q;
	logic              neg_q;
	logic [30:0]       int_acc_q;
	logic [46:0]       dec_acc_q;
	logic [SEEN_W-1:0] seen_q;
	logic              sat_q;

	logic [FC_W-1:0]   fields_d;
	logic [1:0]        phase_d;
	logic              neg_d;
	logic [30:0]       int_acc_d;
	logic [46:0]       dec_acc_d;
	logic [SEEN_W-1:0] seen_d;
	logic              sat_d;

	logic        is_digit;
	logic        is_newline;
	logic        is_delim;
	logic        room;
	logic        has_res;
	logic        fire;
	logic        take_digit;
	logic        frac_mode;
	logic [30:0] int_new;
	logic [46:0] dec_new;
	logic        acc_ovf;

	// Byte classification.
	always_comb begin
		is_digit   = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		is_newline = byte_s1 == CH_NEWLINE;
		is_delim   = is_newline || (byte_s1 == delim);
		room       = fields_q < FC_W'(MAX_FIELDS_PER_LINE);
		has_res    = is_delim && (room || is_newline);
		fire       = valid_s1 && (!has_res || out_free);
		in_stall   = valid_s1 && !fire;
		res_load   = fire && has_res;
	end

	dfnp_digit_acc #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_acc (
		.int_acc  (int_acc_q),
		.dec_acc  (dec_acc_q),
		.digit    (4'(byte_s1 - CH_ZERO)),
		.frac_mode(frac_mode),
		.frac_pos (seen_q),
		.int_next (int_new),
		.dec_next (dec_new),
		.ovf      (acc_ovf)
	);

	// Next scan state for this byte.
	always_comb begin
		fields_d   = fields_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		int_acc_d  = int_acc_q;
		dec_acc_d  = dec_acc_q;
		seen_d     = seen_q;
		sat_d      = sat_q;
		take_digit = 1'b0;
		frac_mode  = phase_q == PH_FRAC;
		if (!is_delim) begin
			if (room) begin
				unique case (phase_q)
					PH_SKIP: begin
						if (byte_s1 == CH_MINUS) begin
							neg_d   = 1'b1;
							phase_d = PH_INT;
						end else if (is_digit) begin
							phase_d    = PH_INT;
							take_digit = 1'b1;
						end else if (byte_s1 == CH_DOT) begin
							phase_d = PH_FRAC;
						end else if (byte_s1 != CH_SPACE) begin
							phase_d = PH_DONE;
						end
					end
					PH_INT: begin
						if (is_digit) begin
							take_digit = 1'b1;
						end else if (byte_s1 == CH_DOT) begin
							phase_d = PH_FRAC;
						end else begin
							phase_d = PH_DONE;
						end
					end
					PH_FRAC: begin
						if (is_digit) begin
							if (seen_q < SEEN_W'(FRAC_DIGITS)) begin
								take_digit = 1'b1;
								seen_d     = seen_q + 1'b1;
							end
						end else begin
							phase_d = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			if (take_digit) begin
				int_acc_d = int_new;
				dec_acc_d = dec_new;
				sat_d     = sat_q | acc_ovf;
			end
		end else if (has_res) begin
			// A closing byte clears the field scan and counts the field; a newline restarts the count.
			if (is_newline) begin
				fields_d = '0;
			end else begin
				fields_d = fields_q + 1'b1;
			end
			phase_d   = PH_SKIP;
			neg_d     = 1'b0;
			int_acc_d = '0;
			dec_acc_d = '0;
			seen_d    = '0;
			sat_d     = 1'b0;
		end
	end

	// Result for a closed field, signed on output.
	always_comb begin
		res.field_index  = IDX_W'(fields_q);
		res.last_in_line = is_newline;
		res.field_kept   = room;
		if (room) begin
			res.int_value     = neg_q ? -$signed({1'b0, int_acc_q}) : $signed({1'b0, int_acc_q});
			res.decimal_value = neg_q ? -$signed({1'b0, dec_acc_q}) : $signed({1'b0, dec_acc_q});
			res.overflowed    = sat_q;
		end else begin
			res.int_value     = '0;
			res.decimal_value = '0;
			res.overflowed    = 1'b0;
		end
	end

	// Byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
		end
	end

	// Field scan state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_q  <= '0;
			phase_q   <= PH_SKIP;
			neg_q     <= 1'b0;
			int_acc_q <= '0;
			dec_acc_q <= '0;
			seen_q    <= '0;
			sat_q     <= 1'b0;
		end else if (fire) begin
			fields_q  <= fields_d;
			phase_q   <= phase_d;
			neg_q     <= neg_d;
			int_acc_q <= int_acc_d;
			dec_acc_q <= dec_acc_d;
			seen_q    <= seen_d;
			sat_q     <= sat_d;
		end
	end

endmodule

[hdl/delimited_field_number_parser.sv]
// Top level of the delimited field number parser: delimiter register, byte
// stage with field scan, and result register. Depends on dfnp_pkg, dfnp_parser.
//
// The block takes one text byte per clock cycle unless a closing byte is held
// up: each byte is registered in the byte register, where the field scan and
// digit accumulation run, and a result beat then sits in the output register
// until the sink takes it. The input stalls only while a closing byte waits for
// the output register to free up; bytes that close no field pass even while a
// result is held. The delimiter register is written through its own port with
// ready always high and must only be changed while no bytes are in flight.
module delimited_field_number_parser #(
	parameter int MAX_FIELDS_PER_LINE = dfnp_pkg::DEF_FIELDS_PER_LINE,
	parameter int FRAC_DIGITS         = dfnp_pkg::DEF_FRAC_DIGITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [7:0]                               delimiter_byte,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [7:0]                               text_byte,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [dfnp_pkg::IDX_W-1:0]               field_index,
	output logic signed [dfnp_pkg::INT_W-1:0]        int_value,
	output logic signed [dfnp_pkg::DEC_W-1:0]        decimal_value,
	output logic                                     overflowed,
	output logic                                     field_kept,
	output logic                                     last_in_line
);
	import dfnp_pkg::*;

	logic [7:0] delim_q;
	logic       out_valid_q;
	res_t       res_q;
	res_t       res;
	logic       res_load;
	logic       out_free;

	// Delimiter register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delim_q <= delimiter_byte;
		end
	end

	dfnp_parser #(
		.MAX_FIELDS_PER_LINE(MAX_FIELDS_PER_LINE),
		.FRAC_DIGITS        (FRAC_DIGITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.text_byte(text_byte),
		.delim    (delim_q),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res)
	);

	// Result register: free when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign field_index   = res_q.field_index;
	assign int_value     = res_q.int_value;
	assign decimal_value = res_q.decimal_value;
	assign overflowed    = res_q.overflowed;
	assign field_kept    = res_q.field_kept;
	assign last_in_line  = res_q.last_in_line;

endmodule

[hdl/dfnp_checker.sv]
// Port-level checks for the delimited field number parser, bound to the top level.
// Depends on dfnp_pkg and the delimited_field_number_parser ports.
module dfnp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [dfnp_pkg::IDX_W-1:0]           field_index,
	input logic signed [dfnp_pkg::INT_W-1:0]    int_value,
	input logic signed [dfnp_pkg::DEC_W-1:0]    decimal_value,
	input logic                                 overflowed,
	input logic                                 field_kept,
	input logic                                 last_in_line
);
	import dfnp_pkg::*;

	// A held result beat stays in place until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(field_index) && $stable(int_value)
			&& $stable(decimal_value) && $stable(overflowed) && $stable(field_kept)
			&& $stable(last_in_line))
		else $error("result beat changed while stalled");

	// A dropped field only reports at the end of its line.
	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !field_kept |-> last_in_line)
		else $error("dropped field result without end of line");

	// A dropped field carries zero values and no overflow.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !field_kept |-> int_value == '0 && decimal_value == '0 && !overflowed)
		else $error("dropped field result carries values");

	// A negative integer always comes with a negative decimal value.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && int_value[INT_W-1] |-> decimal_value[DEC_W-1])
		else $error("integer and decimal signs disagree");

endmodule

bind delimited_field_number_parser dfnp_checker u_dfnp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.field_index  (field_index),
	.int_value    (int_value),
	.decimal_value(decimal_value),
	.overflowed   (overflowed),
	.field_kept   (field_kept),
	.last_in_line (last_in_line)
);

[sim/tb_delimited_field_number_parser.sv]
// Self-checking testbench for delimited_field_number_parser: random text lines go in, each
// closed field is predicted and compared beat by beat. Depends on dfnp_pkg and the RTL.
module tb_delimited_field_number_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import dfnp_pkg::*;

	localparam int FIELD_LIMIT = DEF_FIELDS_PER_LINE;
	localparam int FRAC       = DEF_FRAC_DIGITS;
	localparam int PHASES     = 10;
	localparam int PHASE_BYTES = 55;

	// Delimiter for each random phase; entry 0 is used first.
	localparam logic [PHASES-1:0][7:0] PHASE_DELIMS = {8'd124, 8'd9, 8'd53, 8'd46, 8'd45,
		8'd32, 8'd10, 8'd255, 8'd0, 8'd44};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [7:0]              delimiter_byte = DELIM_RESET;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [7:0]              text_byte = 8'd0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [IDX_W-1:0]        field_index;
	logic signed [INT_W-1:0] int_value;
	logic signed [DEC_W-1:0] decimal_value;
	logic                    overflowed;
	logic                    field_kept;
	logic                    last_in_line;

	// Bytes waiting to be sent, field results still to arrive.
	logic [7:0] text_queue [$];
	res_t       fields_due [$];
	int         bytes_queued = 0;
	int         bytes_taken = 0;
	int         failures = 0;
	int         send_idle_pct = 36;
	int         recv_idle_pct = 80;

	// Predicted parser state.
	logic [7:0]  delimiter_now = DELIM_RESET;
	logic [4:0]  fields_closed = '0;
	logic [1:0]  scan_phase = PH_SKIP;
	logic        is_neg = 1'b0;
	logic [63:0] int_mag = '0;
	logic [63:0] dec_mag = '0;
	logic [2:0]  frac_seen = '0;
	logic        saturated = 1'b0;

	delimited_field_number_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.delimiter_byte(delimiter_byte),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_index(field_index),
		.int_value(int_value),
		.decimal_value(decimal_value),
		.overflowed(overflowed),
		.field_kept(field_kept),
		.last_in_line(last_in_line)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] ten_to(input int n);
		logic [63:0] p;
		p = 64'd1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	// An integer digit moves both magnitudes up one decade, each saturating on its own.
	function automatic void add_int_digit(input logic [63:0] d);
		logic [63:0] v;
		v = int_mag * 10 + d;
		if (v > 64'(INT_MAX_MAG)) begin
			v = 64'(INT_MAX_MAG);
			saturated = 1'b1;
		end
		int_mag = v;
		v = dec_mag * 10 + d * ten_to(FRAC);
		if (v > 64'(DEC_MAX_MAG)) begin
			v = 64'(DEC_MAX_MAG);
			saturated = 1'b1;
		end
		dec_mag = v;
	endfunction

	// Field scan for one byte that does not close the field.
	function automatic void parse_char(input logic [7:0] c);
		logic        digit;
		logic [63:0] d;
		logic [63:0] v;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = 64'(c[3:0]);
		case (scan_phase)
			PH_SKIP: begin
				if (c == CH_MINUS) begin
					is_neg = 1'b1;
					scan_phase = PH_INT;
				end else if (digit) begin
					scan_phase = PH_INT;
					add_int_digit(d);
				end else if (c == CH_DOT) begin
					scan_phase = PH_FRAC;
				end else if (c != CH_SPACE) begin
					scan_phase = PH_DONE;
				end
			end
			PH_INT: begin
				if (digit) begin
					add_int_digit(d);
				end else if (c == CH_DOT) begin
					scan_phase = PH_FRAC;
				end else begin
					scan_phase = PH_DONE;
				end
			end
			PH_FRAC: begin
				// Fraction digits past the kept precision are dropped.
				if (!digit) begin
					scan_phase = PH_DONE;
				end else if (frac_seen < FRAC) begin
					v = dec_mag + d * ten_to(FRAC - 1 - frac_seen);
					if (v > 64'(DEC_MAX_MAG)) begin
						v = 64'(DEC_MAX_MAG);
						saturated = 1'b1;
					end
					dec_mag = v;
					frac_seen++;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Predict the effect of one accepted byte and queue the field result it closes, if any.
	function automatic void scan_text_byte(input logic [7:0] c);
		res_t r;
		logic newline;
		logic room;
		newline = (c == CH_NEWLINE);
		room = (fields_closed < FIELD_LIMIT);
		if (!newline && c != delimiter_now) begin
			if (room) begin
				parse_char(c);
			end
			return;
		end
		if (!room && !newline) begin
			return;
		end
		r.field_index = fields_closed;
		r.last_in_line = newline;
		if (room) begin
			r.int_value = is_neg ? (32'd0 - int_mag[31:0]) : int_mag[31:0];
			r.decimal_value = is_neg ? (48'd0 - dec_mag[47:0]) : dec_mag[47:0];
			r.overflowed = saturated;
			r.field_kept = 1'b1;
			fields_closed++;
		end else begin
			r.int_value = '0;
			r.decimal_value = '0;
			r.overflowed = 1'b0;
			r.field_kept = 1'b0;
		end
		fields_due.push_back(r);
		if (newline) begin
			fields_closed = '0;
		end
		scan_phase = PH_SKIP;
		is_neg = 1'b0;
		int_mag = '0;
		dec_mag = '0;
		frac_seen = '0;
		saturated = 1'b0;
	endfunction

	function automatic void compare_value(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// Driver: a byte beat is held until taken, then the next one may follow after a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				scan_text_byte(text_byte);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					text_byte <= text_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result beat taken is checked against the oldest predicted field.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (fields_due.size() == 0) begin
					$error("unexpected result beat: field_index %0d int_value %0d",
						field_index, int_value);
					failures++;
				end else begin
					compare_value("field_index", 64'(fields_due[0].field_index),
						64'(field_index));
					compare_value("int_value", 64'(fields_due[0].int_value), 64'(int_value));
					compare_value("decimal_value", 64'(fields_due[0].decimal_value),
						64'(decimal_value));
					compare_value("overflowed", 64'(fields_due[0].overflowed),
						64'(overflowed));
					compare_value("field_kept", 64'(fields_due[0].field_kept),
						64'(field_kept));
					compare_value("last_in_line", 64'(fields_due[0].last_in_line),
						64'(last_in_line));
					void'(fields_due.pop_front());
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		text_queue.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			queue_byte(s[i]);
		end
	endtask

	// A mostly well-formed number, sometimes long enough to saturate or placed at a limit.
	task automatic queue_number();
		int n_int;
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) queue_byte(CH_SPACE);
		end
		if ($urandom_range(2) == 0) begin
			queue_byte(CH_MINUS);
		end
		case ($urandom_range(15))
			0: queue_text("214748364");
			1: queue_text("1407374883");
			default: begin
			end
		endcase
		n_int = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6);
		repeat (n_int) queue_byte(CH_ZERO + 8'($urandom_range(9)));
		if ($urandom_range(1) == 1) begin
			queue_byte(CH_DOT);
			repeat ($urandom_range(0, 7)) queue_byte(CH_ZERO + 8'($urandom_range(9)));
		end
		if ($urandom_range(5) == 0) begin
			queue_byte(8'($urandom_range(255)));
		end
	endtask

	// One line; some lines run past the field limit.
	task automatic queue_line();
		int n_fields;
		n_fields = ($urandom_range(5) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 6);
		for (int f = 0; f < n_fields; f++) begin
			if (f != 0) begin
				queue_byte(delimiter_now);
			end
			case ($urandom_range(9))
				0: repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(255)));
				1: begin
				end
				default: queue_number();
			endcase
		end
		queue_byte(CH_NEWLINE);
	endtask

	// Wait until every byte is taken and every field result has come out.
	task automatic wait_drained();
		while (bytes_taken != bytes_queued || fields_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_delimiter(input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		delimiter_byte <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		delimiter_now = value;
	endtask

	// Stimulus: directed bytes with the reset delimiter, then one random phase per delimiter.
	initial begin
		int start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Spaces, sign, extra fraction digits, minus alone, byte extremes, leading dot, empty line.
		queue_text(" -3.14159|-|");
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_text("|.5x9\n\n");
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_delimiter(PHASE_DELIMS[p]);
			if (p < 3) begin
				send_idle_pct = 36;
				recv_idle_pct = 80;
			end else if (p < 6) begin
				send_idle_pct = 80;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			start = bytes_queued;
			while (bytes_queued - start < PHASE_BYTES) queue_line();
			wait_drained();
		end

		if (failures == 0 && fields_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hdl/dfnp_pkg.sv
hdl/dfnp_digit_acc.sv
hdl/dfnp_parser.sv
hdl/delimited_field_number_parser.sv
hdl/dfnp_checker.sv
sim/tb_delimited_field_number_parser.sv
